### hw/rtl/wht_pkg.sv
// Shared types, codes and reset values for the water heater thermostat.
`timescale 1ns / 1ps
package wht_pkg;

	localparam int OP_W   = 3;
	localparam int TEMP_W = 8;
	localparam int SP_W   = 8;
	localparam int TICK_W = 16;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int AVG_COUNT_DEF = 10;

	localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
	localparam logic [OP_W-1:0] OP_POWER  = 3'd1;
	localparam logic [OP_W-1:0] OP_UP     = 3'd2;
	localparam logic [OP_W-1:0] OP_DOWN   = 3'd3;
	localparam logic [OP_W-1:0] OP_SAMPLE = 3'd4;

	localparam logic [2:0] REG_SP_MIN   = 3'd0;
	localparam logic [2:0] REG_SP_MAX   = 3'd1;
	localparam logic [2:0] REG_SP_STEP  = 3'd2;
	localparam logic [2:0] REG_BAND     = 3'd3;
	localparam logic [2:0] REG_SP_INIT  = 3'd4;
	localparam logic [2:0] REG_TIMEOUT  = 3'd5;
	localparam logic [2:0] REG_BLINK    = 3'd6;

	localparam logic [SP_W-1:0]   SP_MIN_DEF  = 8'd35;
	localparam logic [SP_W-1:0]   SP_MAX_DEF  = 8'd75;
	localparam logic [SP_W-1:0]   SP_STEP_DEF = 8'd5;
	localparam logic [SP_W-1:0]   BAND_DEF    = 8'd5;
	localparam logic [SP_W-1:0]   SP_INIT_DEF = 8'd60;
	localparam logic [TICK_W-1:0] TIMEOUT_DEF = 16'd5000;
	localparam logic [TICK_W-1:0] BLINK_DEF   = 16'd1000;

	typedef struct packed {
		logic            heater_on;
		logic            cooler_on;
		logic            led_on;
		logic            power_on;
		logic            setting_mode;
		logic [SP_W-1:0] setpoint;
		logic [SP_W-1:0] shown_value;
	} status_t;

endpackage

### hw/rtl/wht_cmd_if.sv
// Event request channel: operation code and temperature sample.
`timescale 1ns / 1ps
interface wht_cmd_if;
	import wht_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [TEMP_W-1:0] temperature;

	modport source (output valid, output operation, output temperature, input ready);
	modport sink (input valid, input operation, input temperature, output ready);

endinterface

### hw/rtl/wht_status_if.sv
// Status request channel: relay, LED, mode and display outputs.
`timescale 1ns / 1ps
interface wht_status_if;
	import wht_pkg::*;

	logic            valid;
	logic            ready;
	logic            heater_on;
	logic            cooler_on;
	logic            led_on;
	logic            power_on;
	logic            setting_mode;
	logic [SP_W-1:0] setpoint;
	logic [SP_W-1:0] shown_value;

	modport source (output valid, output heater_on, output cooler_on, output led_on,
		output power_on, output setting_mode, output setpoint, output shown_value,
		input ready);
	modport sink (input valid, input heater_on, input cooler_on, input led_on,
		input power_on, input setting_mode, input setpoint, input shown_value,
		output ready);

endinterface

### hw/rtl/water_heater_thermostat_core.sv
// Water heater thermostat core: event handling, sample averaging, hysteresis control.
// A status request is registered in the result register, or in the skid register while stalled.
// Throughput: one event per cycle unless the skid register is full; a two-entry buffer
// (result plus skid register) keeps input accepted while one result waits downstream.
// Reset (arst_n low, asynchronous): power off, operating mode, relays and LED off,
// setpoint 60, averaging cleared, configuration registers to their defaults.
`timescale 1ns / 1ps
module water_heater_thermostat_core #(
	parameter int AVERAGE_COUNT = wht_pkg::AVG_COUNT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	wht_cmd_if.sink                   cmd,
	wht_status_if.source              status,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [wht_pkg::ADDR_W-1:0] paddr,
	input  logic [wht_pkg::DATA_W-1:0] pwdata,
	output logic [wht_pkg::DATA_W-1:0] prdata,
	output logic                      pready
);
	import wht_pkg::*;

	// block length outside 1..16 falls back to 16
	localparam int AvgN       = (AVERAGE_COUNT >= 1 && AVERAGE_COUNT <= 16) ?
		AVERAGE_COUNT : 16;
	localparam int CntW       = $clog2(AvgN + 1);
	localparam int SumW       = SP_W + $clog2(AvgN);
	localparam int RecipShift = SumW + 5;
	localparam int ProdW      = SumW + RecipShift + 1;
	localparam logic [RecipShift:0] RecipMul =
		(RecipShift+1)'(((1 << RecipShift) + AvgN - 1) / AvgN);
	localparam logic [CntW-1:0] AvgLen = CntW'(AvgN);

	// configuration registers
	logic [SP_W-1:0]   sp_min_q, sp_max_q, sp_step_q, band_q, sp_init_q;
	logic [TICK_W-1:0] timeout_q, blink_per_q;

	// control state
	logic              power_q, setting_q, blinking_q, heat_q, cool_q, lamp_q;
	logic [SP_W-1:0]   target_q, last_q;
	logic [TICK_W-1:0] idle_q, bcnt_q;
	logic [SumW-1:0]   sum_q;
	logic [CntW-1:0]   cnt_q;

	// next state
	logic              power_d, setting_d, blinking_d, heat_d, cool_d, lamp_d;
	logic [SP_W-1:0]   target_d, last_d;
	logic [TICK_W-1:0] idle_d, bcnt_d;
	logic [SumW-1:0]   sum_d;
	logic [CntW-1:0]   cnt_d;

	logic [TICK_W-1:0] idle_inc, bcnt_inc;
	logic [SP_W:0]     sp_up, sp_dn;
	logic [SumW-1:0]   sum_inc;
	logic [CntW-1:0]   cnt_inc;
	logic [ProdW-1:0]  prod;
	logic [SP_W-1:0]   avg;
	logic signed [SP_W+1:0] diff, band_s;

	status_t new_st, out_q, skid_q;
	logic    out_valid_q, skid_valid_q;
	logic    push, pop, cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_min_q    <= SP_MIN_DEF;
			sp_max_q    <= SP_MAX_DEF;
			sp_step_q   <= SP_STEP_DEF;
			band_q      <= BAND_DEF;
			sp_init_q   <= SP_INIT_DEF;
			timeout_q   <= TIMEOUT_DEF;
			blink_per_q <= BLINK_DEF;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_SP_MIN:  sp_min_q    <= pwdata[SP_W-1:0];
				REG_SP_MAX:  sp_max_q    <= pwdata[SP_W-1:0];
				REG_SP_STEP: sp_step_q   <= pwdata[SP_W-1:0];
				REG_BAND:    band_q      <= pwdata[SP_W-1:0];
				REG_SP_INIT: sp_init_q   <= pwdata[SP_W-1:0];
				REG_TIMEOUT: timeout_q   <= pwdata[TICK_W-1:0];
				REG_BLINK:   blink_per_q <= pwdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_SP_MIN:  prdata = DATA_W'(sp_min_q);
			REG_SP_MAX:  prdata = DATA_W'(sp_max_q);
			REG_SP_STEP: prdata = DATA_W'(sp_step_q);
			REG_BAND:    prdata = DATA_W'(band_q);
			REG_SP_INIT: prdata = DATA_W'(sp_init_q);
			REG_TIMEOUT: prdata = DATA_W'(timeout_q);
			REG_BLINK:   prdata = DATA_W'(blink_per_q);
			default:     prdata = '0;
		endcase
	end

	assign idle_inc = idle_q + 1'b1;
	assign bcnt_inc = bcnt_q + 1'b1;
	assign sp_up    = {1'b0, target_q} + {1'b0, sp_step_q};
	assign sp_dn    = {1'b0, target_q} - {1'b0, sp_step_q};
	assign sum_inc  = sum_q + SumW'(cmd.temperature);
	assign cnt_inc  = cnt_q + 1'b1;
	// average by reciprocal multiply, exact over the whole sum range
	assign prod     = ProdW'(sum_inc) * ProdW'(RecipMul);
	assign avg      = prod[RecipShift +: SP_W];
	assign diff     = $signed({2'b00, target_q}) - $signed({2'b00, avg});
	assign band_s   = $signed({2'b00, band_q});

	always_comb begin
		power_d    = power_q;
		setting_d  = setting_q;
		blinking_d = blinking_q;
		heat_d     = heat_q;
		cool_d     = cool_q;
		lamp_d     = lamp_q;
		target_d   = target_q;
		last_d     = last_q;
		idle_d     = idle_q;
		bcnt_d     = bcnt_q;
		sum_d      = sum_q;
		cnt_d      = cnt_q;
		case (cmd.operation)
			OP_TICK: begin
				if (setting_q) begin
					if (idle_inc >= timeout_q) begin
						setting_d = 1'b0;
						idle_d    = '0;
					end else begin
						idle_d = idle_inc;
					end
				end
				if (blinking_q) begin
					if (bcnt_inc >= blink_per_q) begin
						lamp_d = ~lamp_q;
						bcnt_d = '0;
					end else begin
						bcnt_d = bcnt_inc;
					end
				end
			end
			OP_POWER: begin
				if (!setting_q) begin
					power_d = ~power_q;
					if (power_q) begin
						heat_d     = 1'b0;
						cool_d     = 1'b0;
						lamp_d     = 1'b0;
						blinking_d = 1'b0;
						bcnt_d     = '0;
					end
				end
			end
			OP_UP, OP_DOWN: begin
				if (power_q) begin
					idle_d = '0;
					if (!setting_q) begin
						setting_d = 1'b1;
					end else if (cmd.operation == OP_UP) begin
						target_d = (sp_up > {1'b0, sp_max_q}) ? sp_max_q : sp_up[SP_W-1:0];
					end else begin
						target_d = (sp_dn[SP_W] || sp_dn[SP_W-1:0] < sp_min_q) ?
							sp_min_q : sp_dn[SP_W-1:0];
					end
				end
			end
			OP_SAMPLE: begin
				last_d = cmd.temperature;
				if (cnt_inc >= AvgLen) begin
					sum_d = '0;
					cnt_d = '0;
					if (power_q && !setting_q) begin
						if (diff >= band_s) begin
							heat_d = 1'b1;
							cool_d = 1'b0;
							if (!blinking_q) begin
								blinking_d = 1'b1;
								bcnt_d     = '0;
							end
						end
						if (-diff >= band_s) begin
							blinking_d = 1'b0;
							bcnt_d     = '0;
							cool_d     = 1'b1;
							heat_d     = 1'b0;
							lamp_d     = 1'b1;
						end
						if (diff == '0) begin
							blinking_d = 1'b0;
							bcnt_d     = '0;
							cool_d     = 1'b0;
							heat_d     = 1'b0;
							lamp_d     = 1'b0;
						end
					end
				end else begin
					sum_d = sum_inc;
					cnt_d = cnt_inc;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		new_st.heater_on    = heat_d;
		new_st.cooler_on    = cool_d;
		new_st.led_on       = lamp_d;
		new_st.power_on     = power_d;
		new_st.setting_mode = setting_d;
		new_st.setpoint     = target_d;
		new_st.shown_value  = setting_d ? target_d : last_d;
	end

	assign cmd.ready = ~skid_valid_q;
	assign push      = cmd.valid & ~skid_valid_q;
	assign pop       = out_valid_q & status.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_q    <= 1'b0;
			setting_q  <= 1'b0;
			blinking_q <= 1'b0;
			heat_q     <= 1'b0;
			cool_q     <= 1'b0;
			lamp_q     <= 1'b0;
			target_q   <= SP_INIT_DEF;
			last_q     <= '0;
			idle_q     <= '0;
			bcnt_q     <= '0;
			sum_q      <= '0;
			cnt_q      <= '0;
		end else if (push) begin
			power_q    <= power_d;
			setting_q  <= setting_d;
			blinking_q <= blinking_d;
			heat_q     <= heat_d;
			cool_q     <= cool_d;
			lamp_q     <= lamp_d;
			target_q   <= target_d;
			last_q     <= last_d;
			idle_q     <= idle_d;
			bcnt_q     <= bcnt_d;
			sum_q      <= sum_d;
			cnt_q      <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || pop) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= push;
				end
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_q <= skid_valid_q ? skid_q : new_st;
		end
		if (out_valid_q && !pop && push) begin
			skid_q <= new_st;
		end
	end

	assign status.valid        = out_valid_q;
	assign status.heater_on    = out_q.heater_on;
	assign status.cooler_on    = out_q.cooler_on;
	assign status.led_on       = out_q.led_on;
	assign status.power_on     = out_q.power_on;
	assign status.setting_mode = out_q.setting_mode;
	assign status.setpoint     = out_q.setpoint;
	assign status.shown_value  = out_q.shown_value;

endmodule

### dv/testbench.sv
// Testbench for water_heater_thermostat_core: predicted status checked against every request.
`timescale 1ns / 1ps
module testbench;
	import wht_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 150;
	localparam int NUM_PHASES  = 8;
	localparam int HOLD_CYCLES = 60;
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	class thermostat_tracker;
		bit blinking;
		status_t cur;
		logic [TEMP_W-1:0] last_temp;
		logic [TICK_W-1:0] idle_cnt;
		logic [TICK_W-1:0] blink_cnt;
		logic [11:0] temp_sum;
		logic [3:0] temp_cnt;
		logic [SP_W-1:0] sp_min, sp_max, sp_step, band;
		logic [TICK_W-1:0] timeout_ticks, blink_ticks;
		status_t pending_status[$];
		int errors;

		function new();
			cur = '0;
			cur.setpoint = SP_INIT_DEF;
			blinking = 0;
			last_temp = '0;
			idle_cnt = '0;
			blink_cnt = '0;
			temp_sum = '0;
			temp_cnt = '0;
			sp_min = SP_MIN_DEF;
			sp_max = SP_MAX_DEF;
			sp_step = SP_STEP_DEF;
			band = BAND_DEF;
			timeout_ticks = TIMEOUT_DEF;
			blink_ticks = BLINK_DEF;
			errors = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [DATA_W-1:0] val);
			case (idx)
				REG_SP_MIN:  sp_min = val[SP_W-1:0];
				REG_SP_MAX:  sp_max = val[SP_W-1:0];
				REG_SP_STEP: sp_step = val[SP_W-1:0];
				REG_BAND:    band = val[SP_W-1:0];
				REG_TIMEOUT: timeout_ticks = val[TICK_W-1:0];
				REG_BLINK:   blink_ticks = val[TICK_W-1:0];
				default: ;
			endcase
		endfunction

		function void stop_blink();
			blinking = 0;
			blink_cnt = '0;
		endfunction

		function void apply_average(logic [TEMP_W-1:0] avg);
			int diff;
			int b;
			diff = int'(cur.setpoint) - int'(avg);
			b = int'(band);
			if (diff >= b) begin
				cur.heater_on = 1;
				cur.cooler_on = 0;
				if (!blinking) begin
					blinking = 1;
					blink_cnt = '0;
				end
			end
			if (-diff >= b) begin
				stop_blink();
				cur.cooler_on = 1;
				cur.heater_on = 0;
				cur.led_on = 1;
			end
			if (diff == 0) begin
				stop_blink();
				cur.cooler_on = 0;
				cur.heater_on = 0;
				cur.led_on = 0;
			end
		endfunction

		function void press(bit up);
			int t;
			if (!cur.power_on)
				return;
			if (!cur.setting_mode) begin
				cur.setting_mode = 1;
				idle_cnt = '0;
				return;
			end
			if (up) begin
				t = int'(cur.setpoint) + int'(sp_step);
				if (t > int'(sp_max))
					t = int'(sp_max);
			end else begin
				t = int'(cur.setpoint) - int'(sp_step);
				if (t < int'(sp_min))
					t = int'(sp_min);
			end
			cur.setpoint = t[SP_W-1:0];
			idle_cnt = '0;
		endfunction

		function void take_event(logic [OP_W-1:0] op, logic [TEMP_W-1:0] temp);
			status_t e;
			case (op)
				OP_TICK: begin
					if (cur.setting_mode) begin
						idle_cnt = idle_cnt + 1'b1;
						if (idle_cnt >= timeout_ticks || timeout_ticks == 0) begin
							cur.setting_mode = 0;
							idle_cnt = '0;
						end
					end
					if (blinking) begin
						blink_cnt = blink_cnt + 1'b1;
						if (blink_cnt >= blink_ticks || blink_ticks == 0) begin
							cur.led_on = !cur.led_on;
							blink_cnt = '0;
						end
					end
				end
				OP_POWER: begin
					if (!cur.setting_mode) begin
						cur.power_on = !cur.power_on;
						if (!cur.power_on) begin
							cur.heater_on = 0;
							cur.cooler_on = 0;
							cur.led_on = 0;
							stop_blink();
						end
					end
				end
				OP_UP:   press(1);
				OP_DOWN: press(0);
				OP_SAMPLE: begin
					last_temp = temp;
					temp_sum = temp_sum + 12'(temp);
					temp_cnt = temp_cnt + 1'b1;
					if (temp_cnt >= AVG_COUNT_DEF) begin
						e.setpoint = 8'(temp_sum / AVG_COUNT_DEF);
						temp_sum = '0;
						temp_cnt = '0;
						if (cur.power_on && !cur.setting_mode)
							apply_average(e.setpoint);
					end
				end
				default: ;
			endcase
			e = cur;
			e.shown_value = cur.setting_mode ? cur.setpoint : last_temp;
			pending_status.push_back(e);
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		task check_status(status_t got);
			status_t e;
			if (pending_status.size() == 0) begin
				report("status request with no event outstanding");
				return;
			end
			e = pending_status.pop_front();
			if (got.heater_on !== e.heater_on)
				report($sformatf("heater_on got %b exp %b", got.heater_on, e.heater_on));
			if (got.cooler_on !== e.cooler_on)
				report($sformatf("cooler_on got %b exp %b", got.cooler_on, e.cooler_on));
			if (got.led_on !== e.led_on)
				report($sformatf("led_on got %b exp %b", got.led_on, e.led_on));
			if (got.power_on !== e.power_on)
				report($sformatf("power_on got %b exp %b", got.power_on, e.power_on));
			if (got.setting_mode !== e.setting_mode)
				report($sformatf("setting_mode got %b exp %b", got.setting_mode,
					e.setting_mode));
			if (got.setpoint !== e.setpoint)
				report($sformatf("setpoint got %0d exp %0d", got.setpoint, e.setpoint));
			if (got.shown_value !== e.shown_value)
				report($sformatf("shown_value got %0d exp %0d", got.shown_value,
					e.shown_value));
		endtask
	endclass

	logic clk = 0;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;

	wht_cmd_if cmd();
	wht_status_if status();

	thermostat_tracker tracker = new();

	int tx_pct;
	int rx_pct;
	int hold_req;
	int cycle_count = 0;
	int samples_sent;
	int press_pct;
	bit center_random;
	logic [TEMP_W-1:0] block_center;

	water_heater_thermostat_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("water_heater_thermostat_core test failed");
			$finish;
		end
	end

	// status sink: check, then pick next ready (long hold-off on request)
	initial begin
		int hold_seen;
		int hold_left;
		status_t got;
		hold_seen = 0;
		hold_left = 0;
		status.ready <= 0;
		forever begin
			@(posedge clk);
			if (status.valid && status.ready) begin
				got.heater_on = status.heater_on;
				got.cooler_on = status.cooler_on;
				got.led_on = status.led_on;
				got.power_on = status.power_on;
				got.setting_mode = status.setting_mode;
				got.setpoint = status.setpoint;
				got.shown_value = status.shown_value;
				tracker.check_status(got);
			end
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				status.ready <= 0;
			end else begin
				status.ready <= !(rx_pct > 0 && $urandom_range(99) < rx_pct);
			end
		end
	end

	task automatic send_event(logic [OP_W-1:0] op, logic [TEMP_W-1:0] temp);
		while (tx_pct > 0 && $urandom_range(99) < tx_pct) begin
			cmd.valid <= 0;
			@(posedge clk);
		end
		cmd.valid <= 1;
		cmd.operation <= op;
		cmd.temperature <= temp;
		do
			@(posedge clk);
		while (!cmd.ready);
		tracker.take_event(op, temp);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] val);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		tracker.set_reg(idx, val);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic drain();
		while (tracker.pending_status.size() > 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic program_regs(int mn, int mx, int stp, int bnd, int init, int tmo, int blk);
		write_reg(REG_SP_MIN, mn);
		write_reg(REG_SP_MAX, mx);
		write_reg(REG_SP_STEP, stp);
		write_reg(REG_BAND, bnd);
		write_reg(REG_SP_INIT, init);
		write_reg(REG_TIMEOUT, tmo);
		write_reg(REG_BLINK, blk);
	endtask

	task automatic configure_phase(int ph);
		case (ph)
			0: program_regs(0, 255, 1, 0, 0, 1, 1);
			1: program_regs(255, 255, 255, 255, 255, 65535, 65535);
			2: program_regs($urandom_range(150, 255), $urandom_range(0, 100),
				$urandom_range(1, 40), $urandom_range(0, 8), $urandom_range(0, 255),
				$urandom_range(1, 12), $urandom_range(1, 6));
			3: program_regs($urandom_range(0, 100), $urandom_range(100, 255),
				$urandom_range(1, 20), $urandom_range(0, 10), $urandom_range(0, 255), 0, 0);
			default: program_regs($urandom_range(0, 100), $urandom_range(100, 255),
				$urandom_range(1, 20), $urandom_range(0, 10), $urandom_range(0, 255),
				$urandom_range(1, 12), $urandom_range(1, 6));
		endcase
	endtask

	task automatic run_directed();
		send_event(OP_UP, 8'h00);
		send_event(OP_POWER, 8'hFF);
		send_event(OP_UP, 8'h00);
		send_event(OP_POWER, 8'h00);
		repeat (4) send_event(OP_UP, 8'h55);
		send_event(OP_DOWN, 8'hAA);
		repeat (2) send_event(OP_TICK, 8'h00);
		for (int o = OP_SPARE_LO; o <= OP_SPARE_HI; o++)
			send_event(o[OP_W-1:0], 8'hFF);
		send_event(OP_SAMPLE, 8'hFF);
		repeat (9) send_event(OP_SAMPLE, 8'h00);
		send_event(OP_TICK, 8'h00);
	endtask

	// samples come in blocks aimed at the heat, cool and equal regions of the band, or random
	task automatic random_event(output logic [OP_W-1:0] op, output logic [TEMP_W-1:0] temp);
		int r;
		int c;
		r = $urandom_range(99);
		temp = TEMP_W'($urandom_range(255));
		if (r < 3)
			op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
		else if (r < 8 || (!tracker.cur.power_on && r < 20))
			op = OP_POWER;
		else if (r < 8 + press_pct)
			op = $urandom_range(1) ? OP_UP : OP_DOWN;
		else if (r < 55)
			op = OP_TICK;
		else begin
			op = OP_SAMPLE;
			if (samples_sent % AVG_COUNT_DEF == 0) begin
				center_random = 0;
				case ($urandom_range(3))
					0: c = int'(tracker.cur.setpoint);
					1: c = int'(tracker.cur.setpoint) - int'(tracker.band)
						- int'($urandom_range(3));
					2: c = int'(tracker.cur.setpoint) + int'(tracker.band)
						+ int'($urandom_range(3));
					default: center_random = 1;
				endcase
				if (c < 0)
					c = 0;
				if (c > 255)
					c = 255;
				block_center = c[TEMP_W-1:0];
			end
			if (!center_random)
				temp = block_center;
			samples_sent++;
		end
	endtask

	initial begin
		logic [OP_W-1:0] op;
		logic [TEMP_W-1:0] temp;
		arst_n = 0;
		hold_req = 0;
		tx_pct = 0;
		rx_pct = 0;
		samples_sent = 0;
		press_pct = 14;
		center_random = 0;
		block_center = '0;
		cmd.valid <= 0;
		cmd.operation <= OP_TICK;
		cmd.temperature <= '0;
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		paddr <= '0;
		pwdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		write_reg(REG_TIMEOUT, 2);
		write_reg(REG_BLINK, 1);
		run_directed();
		cmd.valid <= 0;
		drain();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			configure_phase(ph);
			press_pct = (ph == 1) ? 2 : 14;
			case (ph % 4)
				0: begin tx_pct = 0;  rx_pct <= 0;  end
				1: begin tx_pct = 49; rx_pct <= 0;  end
				2: begin tx_pct = 0;  rx_pct <= 49; end
				default: begin tx_pct = 19; rx_pct <= 19; end
			endcase
			if (ph == 4)
				hold_req <= hold_req + 1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				random_event(op, temp);
				send_event(op, temp);
			end
			cmd.valid <= 0;
			drain();
		end

		repeat (5) @(posedge clk);
		if (tracker.errors == 0)
			$display("water_heater_thermostat_core test passed");
		else
			$display("water_heater_thermostat_core test failed");
		$finish;
	end

endmodule
